// ===== rtl/core/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Item layouts, box layout, default sizes and the clamped edge difference.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

  localparam int MaxDetsDef  = 64;
  localparam int IouLimitRst = 26214;
  localparam int IdxW        = 6;
  localparam int BoxW        = 64;
  localparam int EntryW      = 80;

  typedef struct packed {
    logic        [15:0] score;
    logic signed [15:0] x_left;
    logic signed [15:0] y_top;
    logic signed [15:0] x_right;
    logic signed [15:0] y_bottom;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic        [IdxW-1:0] kept_index;
    logic        [15:0]     kept_score;
    logic signed [15:0]     kept_x_left;
    logic signed [15:0]     kept_y_top;
    logic signed [15:0]     kept_x_right;
    logic signed [15:0]     kept_y_bottom;
    logic                   last_kept;
    logic                   overflowed;
  } out_t;

  typedef struct packed {
    logic signed [15:0] x_left;
    logic signed [15:0] y_top;
    logic signed [15:0] x_right;
    logic signed [15:0] y_bottom;
  } box_t;

  typedef struct packed {
    logic done;
    logic over;
  } iou_res_t;

  // hi - lo clamped at zero; the positive range always fits in 16 bits.
  function automatic logic [15:0] clamp_diff(logic signed [15:0] hi,
                                             logic signed [15:0] lo);
    logic signed [16:0] d;
    d = 17'(hi) - 17'(lo);
    return d[16] ? 16'h0000 : d[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// gbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbs_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/gbs_iou_unit.sv =====
// ----------------------------------------------------------------------------
// gbs_iou_unit: overlap test of two boxes on one shared multiplier
// Computes inter * 65536 > limit * union in registered steps after start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbs_iou_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire gbs_pkg::box_t     box_a,
  input  wire gbs_pkg::box_t     box_b,
  input  wire logic [15:0]       iou_limit,
  output gbs_pkg::iou_res_t      res
);

  localparam logic [2:0] StInter = 3'd1;
  localparam logic [2:0] StAreaA = 3'd2;
  localparam logic [2:0] StAreaB = 3'd3;
  localparam logic [2:0] StUnion = 3'd4;
  localparam logic [2:0] StLimit = 3'd5;
  localparam logic [2:0] StCmp   = 3'd6;

  logic        busy_r;
  logic [2:0]  step_r;
  logic [15:0] iw_r, ih_r, wa_r, ha_r, wb_r, hb_r;
  logic [31:0] inter_r, sum_r;
  logic [32:0] uni_r;
  logic [48:0] prod_r;
  logic [15:0] op_a;
  logic [32:0] op_b;

  always_comb begin
    unique case (step_r)
      StInter: begin op_a = iw_r;      op_b = 33'(ih_r); end
      StAreaA: begin op_a = wa_r;      op_b = 33'(ha_r); end
      StAreaB: begin op_a = wb_r;      op_b = 33'(hb_r); end
      StLimit: begin op_a = iou_limit; op_b = uni_r;     end
      default: begin op_a = '0;        op_b = '0;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= StInter;
    end else if (busy_r) begin
      if (step_r == StCmp) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      iw_r <= gbs_pkg::clamp_diff(
                (box_a.x_right < box_b.x_right) ? box_a.x_right : box_b.x_right,
                (box_a.x_left > box_b.x_left) ? box_a.x_left : box_b.x_left);
      ih_r <= gbs_pkg::clamp_diff(
                (box_a.y_bottom < box_b.y_bottom) ? box_a.y_bottom : box_b.y_bottom,
                (box_a.y_top > box_b.y_top) ? box_a.y_top : box_b.y_top);
      wa_r <= gbs_pkg::clamp_diff(box_a.x_right, box_a.x_left);
      ha_r <= gbs_pkg::clamp_diff(box_a.y_bottom, box_a.y_top);
      wb_r <= gbs_pkg::clamp_diff(box_b.x_right, box_b.x_left);
      hb_r <= gbs_pkg::clamp_diff(box_b.y_bottom, box_b.y_top);
    end
    prod_r <= 49'(op_a) * 49'(op_b);
    if (busy_r && step_r == StAreaA) begin
      inter_r <= prod_r[31:0];
    end
    if (busy_r && step_r == StAreaB) begin
      sum_r <= prod_r[31:0];
    end
    // The intersection never exceeds either area, so the union stays >= 0.
    if (busy_r && step_r == StUnion) begin
      uni_r <= 33'(sum_r) + 33'(prod_r[31:0]) - 33'(inter_r);
    end
  end

  assign res.done = busy_r && (step_r == StCmp);
  assign res.over = {1'b0, inter_r, 16'h0000} > prod_r;

endmodule

`default_nettype wire

// ===== rtl/core/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression of scored boxes
// Loads a set of boxes, then emits the kept boxes in order of selection.
// ----------------------------------------------------------------------------
// One box item is taken a cycle while the set loads; the item marked last
// closes the set, and the block then stalls its input until every kept box
// has been handed out. Each selection is one scan over the loaded boxes (one
// RAM read a cycle) followed by a suppression pass in which every box still
// standing is tested against the kept box on the shared overlap unit. The
// time a set takes is set by the single RAM read port and the one multiplier
// of the overlap unit.
`timescale 1ns / 1ps
`default_nettype none

module greedy_box_suppression #(
  parameter int MAX_DETS = gbs_pkg::MaxDetsDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire gbs_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output gbs_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_DETS);
  localparam int CW = $clog2(MAX_DETS + 1);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StSchk = 3'd2;
  localparam logic [2:0] StSwt  = 3'd3;
  localparam logic [2:0] StSiou = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  logic [2:0]          state_r;
  logic [15:0]         limit_r;
  logic [CW-1:0]       cnt_r, scan_i_r, sup_i_r;
  logic                ovf_r, dv_r, found_r, pend_valid_r, emit_last_r;
  logic [MAX_DETS-1:0] supp_r;
  logic [AW-1:0]       didx_r, best_idx_r, pend_idx_r;
  logic [15:0]         best_score_r, pend_score_r;
  gbs_pkg::box_t       best_box_r, pend_box_r, rd_box, in_box;
  logic                out_valid_r;
  gbs_pkg::out_t       out_data_r;

  logic                     accept, ram_we;
  logic [AW-1:0]            raddr;
  logic [gbs_pkg::EntryW-1:0] rdata;
  logic [15:0]              rd_score;
  logic                     scan_done, out_free;
  gbs_pkg::iou_res_t        iou_res;

  assign in_stall  = (state_r != StLoad);
  assign accept    = in_valid && !in_stall;
  assign ram_we    = accept && (cnt_r != CW'(MAX_DETS));
  assign raddr     = (state_r == StSchk) ? sup_i_r[AW-1:0] : scan_i_r[AW-1:0];
  assign rd_score  = rdata[gbs_pkg::EntryW-1:gbs_pkg::BoxW];
  assign rd_box    = gbs_pkg::box_t'(rdata[gbs_pkg::BoxW-1:0]);
  assign in_box    = '{x_left: in_data.x_left, y_top: in_data.y_top,
                       x_right: in_data.x_right, y_bottom: in_data.y_bottom};
  assign scan_done = (scan_i_r == cnt_r) && !dv_r;
  assign out_free  = !out_valid_r || !out_stall;

  gbs_ram #(.W(gbs_pkg::EntryW), .D(MAX_DETS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_data.score, in_box}),
    .raddr (raddr),
    .rdata (rdata)
  );

  gbs_iou_unit u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == StSwt),
    .box_a     (pend_box_r),
    .box_b     (rd_box),
    .iou_limit (limit_r),
    .res       (iou_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StLoad;
      limit_r      <= 16'(gbs_pkg::IouLimitRst);
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      supp_r       <= '0;
      scan_i_r     <= '0;
      sup_i_r      <= '0;
      dv_r         <= 1'b0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      emit_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (state_r == StEmit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        StLoad: begin
          if (accept) begin
            if (ram_we) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_data.last_item) begin
              scan_i_r <= '0;
              dv_r     <= 1'b0;
              found_r  <= 1'b0;
              state_r  <= StScan;
            end
          end
        end
        StScan: begin
          if (scan_i_r != cnt_r) begin
            scan_i_r <= scan_i_r + CW'(1);
            didx_r   <= scan_i_r[AW-1:0];
            dv_r     <= 1'b1;
          end else begin
            dv_r <= 1'b0;
          end
          // Strict compare in ascending order gives ties to the earlier box.
          if (dv_r && !supp_r[didx_r] && (!found_r || rd_score > best_score_r)) begin
            found_r      <= 1'b1;
            best_idx_r   <= didx_r;
            best_score_r <= rd_score;
            best_box_r   <= rd_box;
          end
          if (scan_done) begin
            if (!found_r) begin
              emit_last_r <= 1'b1;
              state_r     <= StEmit;
            end else begin
              supp_r[best_idx_r] <= 1'b1;
              if (pend_valid_r) begin
                emit_last_r <= 1'b0;
                state_r     <= StEmit;
              end else begin
                pend_valid_r <= 1'b1;
                pend_idx_r   <= best_idx_r;
                pend_score_r <= best_score_r;
                pend_box_r   <= best_box_r;
                sup_i_r      <= '0;
                state_r      <= StSchk;
              end
            end
          end
        end
        StSchk: begin
          if (sup_i_r == cnt_r) begin
            scan_i_r <= '0;
            dv_r     <= 1'b0;
            found_r  <= 1'b0;
            state_r  <= StScan;
          end else if (supp_r[sup_i_r[AW-1:0]]) begin
            sup_i_r <= sup_i_r + CW'(1);
          end else begin
            state_r <= StSwt;
          end
        end
        StSwt: begin
          state_r <= StSiou;
        end
        StSiou: begin
          if (iou_res.done) begin
            if (iou_res.over) begin
              supp_r[sup_i_r[AW-1:0]] <= 1'b1;
            end
            sup_i_r <= sup_i_r + CW'(1);
            state_r <= StSchk;
          end
        end
        StEmit: begin
          // The previous pick is held back until the next scan shows
          // whether it was the final one of the set.
          if (out_free) begin
            out_data_r.kept_index    <= gbs_pkg::IdxW'(pend_idx_r);
            out_data_r.kept_score    <= pend_score_r;
            out_data_r.kept_x_left   <= pend_box_r.x_left;
            out_data_r.kept_y_top    <= pend_box_r.y_top;
            out_data_r.kept_x_right  <= pend_box_r.x_right;
            out_data_r.kept_y_bottom <= pend_box_r.y_bottom;
            out_data_r.last_kept     <= emit_last_r;
            out_data_r.overflowed    <= ovf_r;
            if (emit_last_r) begin
              cnt_r        <= '0;
              ovf_r        <= 1'b0;
              supp_r       <= '0;
              pend_valid_r <= 1'b0;
              state_r      <= StLoad;
            end else begin
              pend_idx_r   <= best_idx_r;
              pend_score_r <= best_score_r;
              pend_box_r   <= best_box_r;
              sup_i_r      <= '0;
              state_r      <= StSchk;
            end
          end
        end
        default: begin
          state_r <= StLoad;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DETS))
    else $error("loaded count beyond capacity");

  a_iou_state: assert property (@(posedge clk) disable iff (!rst_n)
    iou_res.done |-> (state_r == StSiou))
    else $error("overlap result outside the suppression pass");

  a_set_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StEmit && out_free && emit_last_r) |=>
      (state_r == StLoad && cnt_r == '0 && supp_r == '0 && !ovf_r))
    else $error("set state not cleared after its final item");

  a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StEmit) |-> pend_valid_r)
    else $error("emit without a pending pick");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for greedy_box_suppression
// Loads sets of scored boxes under random valid/stall gaps, predicts the kept
// boxes with a behavioural model of greedy suppression and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int Cap = gbs_pkg::MaxDetsDef;
  localparam int WatchLimit = 200000;

  class kept_board;
    logic [15:0]   limit;
    gbs_pkg::in_t  boxes[$];
    logic          dropped;
    gbs_pkg::out_t kept_q[$];
    int            errors;

    function new();
      limit = 16'(gbs_pkg::IouLimitRst);
      dropped = 0;
      errors = 0;
    endfunction

    function longint area(gbs_pkg::in_t b);
      longint w, h;
      w = longint'(b.x_right) - longint'(b.x_left);
      h = longint'(b.y_bottom) - longint'(b.y_top);
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      return w * h;
    endfunction

    function bit overlaps(gbs_pkg::in_t a, gbs_pkg::in_t b);
      longint l, r, t, d, iw, ih, inter, uni;
      l = (a.x_left > b.x_left) ? a.x_left : b.x_left;
      r = (a.x_right < b.x_right) ? a.x_right : b.x_right;
      t = (a.y_top > b.y_top) ? a.y_top : b.y_top;
      d = (a.y_bottom < b.y_bottom) ? a.y_bottom : b.y_bottom;
      iw = r - l;
      ih = d - t;
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = area(a) + area(b) - inter;
      return inter * 65536 > longint'(limit) * uni;
    endfunction

    function void note_box(gbs_pkg::in_t it);
      bit            gone[Cap];
      int            best;
      gbs_pkg::out_t r;
      if (boxes.size() < Cap) boxes = {boxes, it};
      else dropped = 1;
      if (!it.last_item) return;
      foreach (gone[i]) gone[i] = 0;
      forever begin
        best = -1;
        foreach (boxes[i])
          if (!gone[i] && (best < 0 || boxes[i].score > boxes[best].score)) best = i;
        if (best < 0) break;
        gone[best] = 1;
        foreach (boxes[i])
          if (!gone[i] && overlaps(boxes[best], boxes[i])) gone[i] = 1;
        r.kept_index = best[gbs_pkg::IdxW-1:0];
        r.kept_score = boxes[best].score;
        r.kept_x_left = boxes[best].x_left;
        r.kept_y_top = boxes[best].y_top;
        r.kept_x_right = boxes[best].x_right;
        r.kept_y_bottom = boxes[best].y_bottom;
        r.last_kept = 0;
        r.overflowed = dropped;
        kept_q = {kept_q, r};
      end
      kept_q[kept_q.size()-1].last_kept = 1;
      boxes.delete();
      dropped = 0;
    endfunction

    function void check_kept(gbs_pkg::out_t got);
      gbs_pkg::out_t e;
      if (kept_q.size() == 0) begin
        $error("unexpected kept box index %0d", got.kept_index);
        errors++;
        return;
      end
      e = kept_q.pop_front();
      if (got.kept_index !== e.kept_index) begin
        $error("kept_index exp %0d got %0d", e.kept_index, got.kept_index); errors++;
      end
      if (got.kept_score !== e.kept_score) begin
        $error("kept_score exp %h got %h", e.kept_score, got.kept_score); errors++;
      end
      if (got.kept_x_left !== e.kept_x_left) begin
        $error("kept_x_left exp %h got %h", e.kept_x_left, got.kept_x_left); errors++;
      end
      if (got.kept_y_top !== e.kept_y_top) begin
        $error("kept_y_top exp %h got %h", e.kept_y_top, got.kept_y_top); errors++;
      end
      if (got.kept_x_right !== e.kept_x_right) begin
        $error("kept_x_right exp %h got %h", e.kept_x_right, got.kept_x_right); errors++;
      end
      if (got.kept_y_bottom !== e.kept_y_bottom) begin
        $error("kept_y_bottom exp %h got %h", e.kept_y_bottom, got.kept_y_bottom); errors++;
      end
      if (got.last_kept !== e.last_kept) begin
        $error("last_kept exp %b got %b", e.last_kept, got.last_kept); errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $error("overflowed exp %b got %b", e.overflowed, got.overflowed); errors++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_stall;
  gbs_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1;
  gbs_pkg::out_t out_data;
  logic          cfg_we = 0;
  logic [15:0]   cfg_wdata = '0;

  kept_board board = new();
  int  sent = 0;
  int  kept_seen = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;

  always #1 clk = ~clk;

  greedy_box_suppression i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Accepted items are noted and results checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_box(in_data);
    if (rst_n && out_valid && !out_stall) begin
      board.check_kept(out_data);
      kept_seen++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver stalls at random, with calm stretches now and then.
  initial begin
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        out_stall <= 0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else if ($urandom_range(0, 30) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        @(negedge clk);
      end
    end
  end

  // Valid stays high after an accepted item until the next call either
  // presents a new item or drops it for a gap, or end_burst drops it.
  task automatic send_box(input gbs_pkg::in_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic end_burst();
    in_valid <= 0;
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    while (board.kept_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.limit = v;
  endtask

  function automatic gbs_pkg::in_t rand_box(bit last, bit wide);
    gbs_pkg::in_t b;
    logic signed [15:0] x, y;
    b.score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) * 16384)
                                           : 16'($urandom);
    if (wide) begin
      b.x_left = 16'($urandom); b.y_top = 16'($urandom);
      b.x_right = 16'($urandom); b.y_bottom = 16'($urandom);
    end else begin
      // Clustered boxes so that overlaps and suppression happen often.
      x = $signed(16'($urandom_range(0, 800))) - 16'sd400;
      y = $signed(16'($urandom_range(0, 800))) - 16'sd400;
      b.x_left = x; b.y_top = y;
      b.x_right = x + $signed(16'($urandom_range(0, 300))) - 16'sd20;
      b.y_bottom = y + $signed(16'($urandom_range(0, 300))) - 16'sd20;
    end
    b.last_item = last;
    return b;
  endfunction

  task automatic send_set(input int n, input bit wide);
    for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1, wide));
    end_burst();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, a single box, equal scores, zero-area pairs.
    send_box('{16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0});
    send_box('{16'h0000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0});
    send_box('{16'hFFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1});
    send_box('{16'h1234, 16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b1});
    send_box('{16'h5000, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b0});
    send_box('{16'h5000, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b0});
    send_box('{16'h5000, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 1'b0});
    send_box('{16'h4FFF, 16'sd1, 16'sd1, 16'sd101, 16'sd101, 1'b1});
    end_burst();
    write_limit(16'h0000);
    send_set(5, 0);
    write_limit(16'hFFFF);
    send_set(5, 0);
    // Capacity exceeded: the overflow flag must ride on every kept box.
    write_limit(16'h8000);
    send_set(Cap + 3, 0);

    while (sent < 370) begin
      case ($urandom_range(0, 5))
        0: write_limit(16'($urandom));
        1: write_limit(16'(gbs_pkg::IouLimitRst));
        default: ;
      endcase
      send_set(($urandom_range(0, 9) == 0) ? $urandom_range(30, Cap + 2)
                                           : $urandom_range(1, 10),
               $urandom_range(0, 4) == 0);
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.kept_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Loaded %0d boxes and checked %0d kept boxes across several thresholds.",
             sent, kept_seen);
    if (board.errors == 0 && board.kept_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
